>>> design/ufr_pkg.sv
// Shared constants, codes and types of the upload frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package ufr_pkg;

    // Frame geometry
    localparam int FRAME_BYTES   = 360;
    localparam int HEADER_BYTES  = 12;
    localparam int PAYLOAD_BYTES = FRAME_BYTES - HEADER_BYTES;

    // Widths derived from the geometry and the fixed field widths
    localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
    localparam int PAY_AW = $clog2(PAYLOAD_BYTES);
    localparam int LEN_W  = 9;
    localparam int EXP_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int CFG_IW = 2;

    // Commands
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_READY  = 3'd1;
    localparam logic [2:0] ST_STATE_ERR  = 3'd2;
    localparam logic [2:0] ST_FORMAT_ERR = 3'd3;
    localparam logic [2:0] ST_LENGTH_ERR = 3'd4;

    // Configuration register indexes and reset values
    localparam logic [CFG_IW-1:0] CFG_MIN_PAYLOAD = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MAX_PAYLOAD = 2'd1;
    localparam logic [LEN_W-1:0]  MIN_RESET       = 9'd1;
    localparam logic [LEN_W-1:0]  MAX_RESET       = 9'd348;

    // Header magic, ASCII
    localparam logic [7:0] MAGIC_0 = 8'h53;
    localparam logic [7:0] MAGIC_1 = 8'h43;
    localparam logic [7:0] MAGIC_2 = 8'h55;
    localparam logic [7:0] MAGIC_3 = 8'h50;

    // Limits of the header id fields
    localparam logic [7:0] DEV_ID_MIN  = 8'd1;
    localparam logic [7:0] DEV_ID_MAX  = 8'd2;
    localparam logic [7:0] CHAN_ID_MAX = 8'd3;
    localparam logic [7:0] CHAN_IDLE   = 8'hFF;

    typedef logic [HEADER_BYTES-1:0][7:0] hdr_t;

    typedef struct packed {
        logic             format_ok;
        logic             length_ok;
        logic [LEN_W-1:0] length;
    } hdr_chk_t;

    typedef struct packed {
        logic              en;
        logic [PAY_AW-1:0] addr;
        logic [7:0]        data;
    } pay_wr_t;

endpackage

`default_nettype wire

>>> design/upload_frame_receiver.sv
// Upload frame receiver top level: input register, frame state and result register.
//
//  Channel  Direction  Handshake            Beat contents
//  s_       in         s_valid / s_ready    command, data_byte, read_index
//  m_       out        m_valid / m_ready    status, ids, length, payload byte
//  cfg_     in         cfg_valid/cfg_ready  register index, write data
//
// One beat is taken every cycle unless a stalled result blocks; each beat goes through
// the input register, where all its work is done, and then into the result register.
// Synchronous reset clears the frame counters, the phase and the error code, and
// loads the payload limits with 1 and 348; the payload store needs no clearing pass.
// A stalled result holds in the result register; the input register then fills and
// s_ready falls until m_ready returns.
`timescale 1ns / 1ps
`default_nettype none

module upload_frame_receiver (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_command,
    input  logic [7:0]                  s_data_byte,
    input  logic [8:0]                  s_read_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_status,
    output logic [1:0]                  m_device_id,
    output logic [7:0]                  m_channel_id,
    output logic [8:0]                  m_payload_length,
    output logic [7:0]                  m_payload_byte,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ufr_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [ufr_pkg::LEN_W-1:0]   cfg_data
);
    import ufr_pkg::*;

    typedef enum logic [1:0] {
        PH_RECEIVING,
        PH_READY,
        PH_ERROR
    } phase_t;

    // Input register
    logic             in_valid_reg, in_valid_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [7:0]       byte_reg, byte_next;
    logic [8:0]       idx_reg, idx_next;

    // Frame state
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] body_reg, body_next;
    logic [2:0]       err_reg, err_next;
    hdr_t             hdr_reg, hdr_next;
    logic [LEN_W-1:0] min_reg, min_next;
    logic [LEN_W-1:0] max_reg, max_next;

    // Result register
    logic             m_valid_reg, m_valid_next;
    logic [2:0]       status_reg, status_next;
    logic [1:0]       dev_reg, dev_next;
    logic [7:0]       chan_reg, chan_next;
    logic [LEN_W-1:0] plen_reg, plen_next;
    logic             psel_reg, psel_next;

    logic             s_accept;
    logic             out_free;
    logic             advance;
    logic             push_ok;
    logic [CNT_W-1:0] count_inc;
    logic [EXP_W-1:0] expect_cnt;
    hdr_chk_t         chk;
    pay_wr_t          pay_wr;
    logic             rd_en;
    logic [7:0]       rd_data;

    // Handshakes
    assign out_free  = !m_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // A push is stored only while receiving and while the frame has room
    assign push_ok    = advance && (cmd_reg == CMD_PUSH) && (phase_reg == PH_RECEIVING) &&
                        (count_reg < CNT_W'(FRAME_BYTES));
    assign count_inc  = count_reg + 1'b1;
    assign expect_cnt = EXP_W'(HEADER_BYTES) + EXP_W'(chk.length);

    ufr_hdr_check u_hdr_check (
        .hdr         (hdr_next),
        .min_payload (min_reg),
        .max_payload (max_reg),
        .chk         (chk)
    );

    // Payload bytes go to the store, header bytes to registers
    always_comb begin
        pay_wr.en   = push_ok && (count_reg >= CNT_W'(HEADER_BYTES));
        pay_wr.addr = PAY_AW'(count_reg - CNT_W'(HEADER_BYTES));
        pay_wr.data = byte_reg;
    end

    assign rd_en = advance && (cmd_reg == CMD_QUERY) && (phase_reg == PH_READY) &&
                   (idx_reg < body_reg);

    ufr_payload_mem u_payload_mem (
        .aclk    (aclk),
        .wr      (pay_wr),
        .rd_en   (rd_en),
        .rd_addr (PAY_AW'(idx_reg)),
        .rd_data (rd_data)
    );

    // Next state of the input register, the frame and the result
    always_comb begin
        in_valid_next = in_valid_reg;
        cmd_next      = cmd_reg;
        byte_next     = byte_reg;
        idx_next      = idx_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        body_next     = body_reg;
        err_next      = err_reg;
        hdr_next      = hdr_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        m_valid_next  = m_valid_reg;
        status_next   = status_reg;
        dev_next      = dev_reg;
        chan_next     = chan_reg;
        plen_next     = plen_reg;
        psel_next     = psel_reg;

        // Input register load and drain
        if (s_accept) begin
            in_valid_next = 1'b1;
            cmd_next      = s_command;
            byte_next     = s_data_byte;
            idx_next      = s_read_index;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        // Configuration writes; unknown indexes are ignored
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_PAYLOAD: min_next = cfg_data;
                CFG_MAX_PAYLOAD: max_next = cfg_data;
                default:         ;
            endcase
        end

        // Header bytes are captured at their own positions
        if (push_ok) begin
            for (int i = 0; i < HEADER_BYTES; i++) begin
                if (count_reg == CNT_W'(i)) begin
                    hdr_next[i] = byte_reg;
                end
            end
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // Work of the beat held in the input register
        if (advance) begin
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            dev_next     = 2'd0;
            chan_next    = CHAN_IDLE;
            plen_next    = '0;
            psel_next    = 1'b0;
            case (cmd_reg)
                CMD_PUSH: begin
                    if (phase_reg != PH_RECEIVING) begin
                        status_next = ST_STATE_ERR;
                    end else if (!push_ok) begin
                        status_next = ST_LENGTH_ERR;
                        err_next    = ST_LENGTH_ERR;
                        phase_next  = PH_ERROR;
                    end else begin
                        count_next = count_inc;
                        if (count_inc < CNT_W'(HEADER_BYTES)) begin
                            status_next = ST_NOT_READY;
                        end else if (!chk.format_ok) begin
                            status_next = ST_FORMAT_ERR;
                            err_next    = ST_FORMAT_ERR;
                            phase_next  = PH_ERROR;
                        end else if (!chk.length_ok) begin
                            status_next = ST_LENGTH_ERR;
                            err_next    = ST_LENGTH_ERR;
                            phase_next  = PH_ERROR;
                        end else begin
                            body_next = chk.length;
                            if (EXP_W'(count_inc) > expect_cnt) begin
                                status_next = ST_LENGTH_ERR;
                                err_next    = ST_LENGTH_ERR;
                                phase_next  = PH_ERROR;
                            end else if (EXP_W'(count_inc) < expect_cnt) begin
                                status_next = ST_NOT_READY;
                            end else begin
                                status_next = ST_OK;
                                phase_next  = PH_READY;
                            end
                        end
                    end
                end
                CMD_QUERY: begin
                    case (phase_reg)
                        PH_ERROR:     status_next = err_reg;
                        PH_RECEIVING: status_next = ST_NOT_READY;
                        PH_READY: begin
                            status_next = ST_OK;
                            dev_next    = hdr_reg[4][1:0];
                            chan_next   = hdr_reg[5];
                            plen_next   = body_reg;
                            psel_next   = idx_reg < body_reg;
                        end
                        default:      status_next = ST_NOT_READY;
                    endcase
                end
                CMD_CLEAR: begin
                    count_next = '0;
                    body_next  = '0;
                    err_next   = ST_OK;
                    phase_next = PH_RECEIVING;
                end
                default: ;
            endcase
        end
    end

    // State, registers and registered outputs
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        byte_reg   <= byte_next;
        idx_reg    <= idx_next;
        hdr_reg    <= hdr_next;
        status_reg <= status_next;
        dev_reg    <= dev_next;
        chan_reg   <= chan_next;
        plen_reg   <= plen_next;
        psel_reg   <= psel_next;
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_RECEIVING;
            count_reg    <= '0;
            body_reg     <= '0;
            err_reg      <= ST_OK;
            min_reg      <= MIN_RESET;
            max_reg      <= MAX_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            body_reg     <= body_next;
            err_reg      <= err_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
        end
    end

    // Result channel
    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_device_id      = dev_reg;
    assign m_channel_id     = chan_reg;
    assign m_payload_length = plen_reg;
    assign m_payload_byte   = psel_reg ? rd_data : 8'd0;

    // A complete frame holds exactly its header and its payload
    a_ready_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_READY) |->
        (EXP_W'(count_reg) == EXP_W'(HEADER_BYTES) + EXP_W'(body_reg)))
        else $error("ready frame with mismatched byte count");

    // The byte count never passes the frame size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FRAME_BYTES))
        else $error("byte count beyond frame size");

    // An error code is latched exactly while in the error phase
    a_err_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ERROR) == (err_reg != ST_OK))
        else $error("latched error out of step with phase");

    // A beat leaving the input register always lands in the result register
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("beat lost between stages");

    // A device id is only reported with an ok status
    a_dev_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (dev_reg != 2'd0)) |-> (status_reg == ST_OK))
        else $error("device id reported with a failing status");

endmodule

`default_nettype wire

>>> design/ufr_hdr_check.sv
// Header format and payload length check.
`timescale 1ns / 1ps
`default_nettype none

module ufr_hdr_check (
    input  ufr_pkg::hdr_t                    hdr,
    input  logic [ufr_pkg::LEN_W-1:0]        min_payload,
    input  logic [ufr_pkg::LEN_W-1:0]        max_payload,
    output ufr_pkg::hdr_chk_t                chk
);
    import ufr_pkg::*;

    logic [31:0] len32;

    // Little-endian length word from the last four header bytes
    assign len32 = {hdr[11], hdr[10], hdr[9], hdr[8]};

    // Magic, id ranges and the two zero bytes
    assign chk.format_ok = (hdr[0] == MAGIC_0) && (hdr[1] == MAGIC_1) &&
                           (hdr[2] == MAGIC_2) && (hdr[3] == MAGIC_3) &&
                           (hdr[4] >= DEV_ID_MIN) && (hdr[4] <= DEV_ID_MAX) &&
                           (hdr[5] <= CHAN_ID_MAX) &&
                           (hdr[6] == 8'd0) && (hdr[7] == 8'd0);

    // The upper bits must be clear, since the limits fit in the low bits
    assign chk.length_ok = (len32[31:LEN_W] == '0) &&
                           (len32[LEN_W-1:0] >= min_payload) &&
                           (len32[LEN_W-1:0] <= max_payload);

    assign chk.length = len32[LEN_W-1:0];

endmodule

`default_nettype wire

>>> design/ufr_payload_mem.sv
// Payload byte store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ufr_payload_mem (
    input  logic                       aclk,
    input  ufr_pkg::pay_wr_t           wr,
    input  logic                       rd_en,
    input  logic [ufr_pkg::PAY_AW-1:0] rd_addr,
    output logic [7:0]                 rd_data
);
    import ufr_pkg::*;

    logic [7:0] mem [PAYLOAD_BYTES];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port; the data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the upload frame receiver: directed beats, then random frames.
`timescale 1ns / 1ps

module tb_top;
    import ufr_pkg::*;

    // Run limits
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned SHOWN_ERRORS = 10;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned OPENING_ROWS = 20;

    // The command code that the block has no use for
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        RX_COLLECT,
        RX_DONE,
        RX_FAULT
    } rx_phase_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [1:0]       dev_id;
        logic [7:0]       chan_id;
        logic [LEN_W-1:0] pay_len;
        logic [7:0]       pay_byte;
    } ufr_result_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  data;
        logic [8:0]  idx;
        bit          typed;
        ufr_result_t want;
    } opening_row_t;

    // Results that can be read straight off the frame rules
    localparam ufr_result_t RES_NOT_READY = '{ST_NOT_READY, 2'd0, CHAN_IDLE, 9'd0, 8'd0};
    localparam ufr_result_t RES_OK_IDLE   = '{ST_OK, 2'd0, CHAN_IDLE, 9'd0, 8'd0};
    localparam ufr_result_t RES_STATE_ERR = '{ST_STATE_ERR, 2'd0, CHAN_IDLE, 9'd0, 8'd0};
    localparam ufr_result_t RES_NO_RESULT = '0;

    logic                aclk;
    logic                aresetn          = 1'b0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [1:0]          s_command        = CMD_QUERY;
    logic [7:0]          s_data_byte      = 8'd0;
    logic [8:0]          s_read_index     = 9'd0;
    logic                m_valid;
    logic                m_ready          = 1'b1;
    logic [2:0]          m_status;
    logic [1:0]          m_device_id;
    logic [7:0]          m_channel_id;
    logic [8:0]          m_payload_length;
    logic [7:0]          m_payload_byte;
    logic                cfg_valid        = 1'b0;
    logic                cfg_ready;
    logic [CFG_IW-1:0]   cfg_index        = CFG_MIN_PAYLOAD;
    logic [LEN_W-1:0]    cfg_data         = '0;

    // Shadow state of the frame receiver
    logic [7:0]          frame_mem [FRAME_BYTES];
    int unsigned         rx_count   = 0;
    int unsigned         body_len   = 0;
    rx_phase_t           rx_phase   = RX_COLLECT;
    logic [2:0]          held_error = ST_OK;
    logic [LEN_W-1:0]    cfg_min    = MIN_RESET;
    logic [LEN_W-1:0]    cfg_max    = MAX_RESET;

    ufr_result_t         expected_results [$];
    int unsigned         beats_sent     = 0;
    int unsigned         results_seen   = 0;
    int unsigned         frames_sent    = 0;
    int unsigned         fail_count     = 0;
    int unsigned         cycle_count    = 0;
    int unsigned         src_idle_pct   = 0;
    int unsigned         sink_stall_pct = 0;

    // Directed opening: idle checks, one short frame with extreme ids, then misuse
    opening_row_t opening_rows [OPENING_ROWS] = '{
        '{CMD_QUERY,  8'h00,       9'd0,   1'b1, RES_NOT_READY},
        '{CMD_UNUSED, 8'hFF,       9'd347, 1'b1, RES_OK_IDLE},
        '{CMD_PUSH,   MAGIC_0,     9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   MAGIC_1,     9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   MAGIC_2,     9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   MAGIC_3,     9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   DEV_ID_MAX,  9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   CHAN_ID_MAX, 9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   8'h00,       9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   8'h00,       9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   8'h01,       9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   8'h00,       9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   8'h00,       9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   8'h00,       9'd0,   1'b1, RES_NOT_READY},
        '{CMD_PUSH,   8'hFF,       9'd0,   1'b1, RES_OK_IDLE},
        '{CMD_QUERY,  8'h00,       9'd0,   1'b0, RES_NO_RESULT},
        '{CMD_QUERY,  8'h00,       9'd347, 1'b1,
          '{ST_OK, 2'd2, CHAN_ID_MAX, 9'd1, 8'd0}},
        '{CMD_PUSH,   8'h00,       9'd0,   1'b1, RES_STATE_ERR},
        '{CMD_CLEAR,  8'h00,       9'd0,   1'b1, RES_OK_IDLE},
        '{CMD_QUERY,  8'h00,       9'd0,   1'b1, RES_NOT_READY}
    };

    // Payload limits, idling mode and random beat budget of each phase
    int unsigned plan_min   [PHASES] = '{1, 0, 0, 348, 3, 40, 2, 1};
    int unsigned plan_max   [PHASES] = '{348, 348, 0, 348, 40, 3, 300, 348};
    int unsigned plan_mode  [PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3};
    int unsigned plan_beats [PHASES] = '{150, 150, 110, 1, 170, 80, 180, 150};

    upload_frame_receiver u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_data_byte      (s_data_byte),
        .s_read_index     (s_read_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_device_id      (m_device_id),
        .m_channel_id     (m_channel_id),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Watchdog against a hung handshake
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Result channel back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Works out the result of one accepted beat and advances the shadow state.
    function automatic ufr_result_t predict_frame_rx(input logic [1:0] cmd,
                                                     input logic [7:0] data,
                                                     input logic [8:0] idx);
        ufr_result_t r;
        logic [31:0] hdr_len;
        logic        hdr_bad;
        int unsigned need;
        logic [2:0]  fault;

        r     = RES_OK_IDLE;
        fault = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (rx_phase != RX_COLLECT) begin
                    r.status = ST_STATE_ERR;
                end else if (rx_count >= FRAME_BYTES) begin
                    fault = ST_LENGTH_ERR;
                end else begin
                    frame_mem[rx_count] = data;
                    rx_count++;
                    if (rx_count < HEADER_BYTES) begin
                        r.status = ST_NOT_READY;
                    end else begin
                        // The whole header is checked again on every push past it
                        hdr_bad = frame_mem[0] != MAGIC_0 || frame_mem[1] != MAGIC_1 ||
                                  frame_mem[2] != MAGIC_2 || frame_mem[3] != MAGIC_3 ||
                                  frame_mem[4] < DEV_ID_MIN || frame_mem[4] > DEV_ID_MAX ||
                                  frame_mem[5] > CHAN_ID_MAX ||
                                  frame_mem[6] != 8'd0 || frame_mem[7] != 8'd0;
                        hdr_len = {frame_mem[11], frame_mem[10], frame_mem[9], frame_mem[8]};
                        if (hdr_bad) begin
                            fault = ST_FORMAT_ERR;
                        end else if (hdr_len < cfg_min || hdr_len > cfg_max) begin
                            fault = ST_LENGTH_ERR;
                        end else begin
                            body_len = hdr_len[LEN_W-1:0];
                            need     = HEADER_BYTES + body_len;
                            if (rx_count > need) begin
                                fault = ST_LENGTH_ERR;
                            end else if (rx_count < need) begin
                                r.status = ST_NOT_READY;
                            end else begin
                                rx_phase = RX_DONE;
                            end
                        end
                    end
                end
                if (fault != ST_OK) begin
                    held_error = fault;
                    rx_phase   = RX_FAULT;
                    r.status   = fault;
                end
            end
            CMD_QUERY: begin
                if (rx_phase == RX_FAULT) begin
                    r.status = held_error;
                end else if (rx_phase != RX_DONE) begin
                    r.status = ST_NOT_READY;
                end else begin
                    r.dev_id  = frame_mem[4][1:0];
                    r.chan_id = frame_mem[5];
                    r.pay_len = body_len[LEN_W-1:0];
                    if (idx < body_len) begin
                        r.pay_byte = frame_mem[HEADER_BYTES + idx];
                    end
                end
            end
            CMD_CLEAR: begin
                rx_count   = 0;
                body_len   = 0;
                held_error = ST_OK;
                rx_phase   = RX_COLLECT;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Drives one beat, idling first at random, and records its expected result.
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] data,
                             input logic [8:0] idx, input bit typed,
                             input ufr_result_t want);
        ufr_result_t predicted;

        @(negedge aclk);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_data_byte  <= data;
        s_read_index <= idx;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_frame_rx(cmd, data, idx);
        expected_results.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    // Holds the sender back until every outstanding result has come out.
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [CFG_IW-1:0] index, input logic [LEN_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == CFG_MIN_PAYLOAD) begin
            cfg_min = value;
        end else begin
            cfg_max = value;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One frame attempt: mostly well formed, sometimes corrupt, cut short or plain noise.
    task automatic send_frame();
        int unsigned kind;
        int unsigned len;
        int unsigned nbytes;
        int unsigned extra;
        int unsigned pos;
        logic [7:0]  hdr [HEADER_BYTES];
        logic [31:0] len_word;
        logic [7:0]  d;
        logic [8:0]  i;

        kind = $urandom_range(0, 99);
        frames_sent++;

        // Noise: any command with any content
        if (kind >= 95) begin
            repeat ($urandom_range(3, 12)) begin
                send_beat(2'($urandom_range(CMD_PUSH, CMD_CLEAR)), 8'($urandom_range(0, 255)),
                          9'($urandom_range(0, 347)), 1'b0, RES_NO_RESULT);
            end
            return;
        end

        // Mostly short payloads, now and then anywhere within the limits
        if (cfg_min <= cfg_max) begin
            if ($urandom_range(0, 99) < 4) begin
                len = $urandom_range(cfg_min, cfg_max);
            end else begin
                len = $urandom_range(cfg_min, (cfg_max - cfg_min > 24) ? cfg_min + 24 : cfg_max);
            end
        end else begin
            len = $urandom_range(0, 40);
        end
        len_word = len;

        // Length outside the limits, including values that only the upper bytes spoil
        if (kind >= 80 && kind < 90) begin
            case ($urandom_range(0, 2))
                0: len_word[16 + $urandom_range(0, 15)] = 1'b1;
                1: begin
                    if (cfg_max < 9'h1FF) begin
                        len_word = $urandom_range(cfg_max + 1, 9'h1FF);
                    end else begin
                        len_word[24] = 1'b1;
                    end
                end
                default: begin
                    if (cfg_min > 0) begin
                        len_word = $urandom_range(0, cfg_min - 1);
                    end else begin
                        len_word[31] = 1'b1;
                    end
                end
            endcase
        end

        hdr[0]  = MAGIC_0;
        hdr[1]  = MAGIC_1;
        hdr[2]  = MAGIC_2;
        hdr[3]  = MAGIC_3;
        hdr[4]  = 8'($urandom_range(DEV_ID_MIN, DEV_ID_MAX));
        hdr[5]  = 8'($urandom_range(0, CHAN_ID_MAX));
        hdr[6]  = 8'd0;
        hdr[7]  = 8'd0;
        hdr[8]  = len_word[7:0];
        hdr[9]  = len_word[15:8];
        hdr[10] = len_word[23:16];
        hdr[11] = len_word[31:24];

        // Spoil one of the fixed header fields
        if (kind >= 70 && kind < 80) begin
            pos = $urandom_range(0, 7);
            case (pos)
                4:       hdr[4] = $urandom_range(0, 1) ? 8'd0 :
                                  8'($urandom_range(DEV_ID_MAX + 1, 255));
                5:       hdr[5] = 8'($urandom_range(CHAN_ID_MAX + 1, 255));
                6, 7:    hdr[pos] = 8'($urandom_range(1, 255));
                default: hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
            endcase
        end

        if (kind < 70) begin
            nbytes = HEADER_BYTES + len;
            extra  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        end else if (kind < 90) begin
            nbytes = HEADER_BYTES;
            extra  = $urandom_range(0, 3);
        end else begin
            nbytes = $urandom_range(1, HEADER_BYTES - 1 + len);
            extra  = 0;
        end

        for (int b = 0; b < nbytes + extra; b++) begin
            if ($urandom_range(0, 99) < 4) begin
                send_beat(CMD_QUERY, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 347)),
                          1'b0, RES_NO_RESULT);
            end
            d = (b < HEADER_BYTES) ? hdr[b] : 8'($urandom_range(0, 255));
            send_beat(CMD_PUSH, d, 9'($urandom_range(0, 347)), 1'b0, RES_NO_RESULT);
        end

        // Read back, mostly inside the payload
        repeat ($urandom_range(1, 4)) begin
            if (len > 0 && $urandom_range(0, 99) < 70) begin
                i = 9'($urandom_range(0, len - 1));
            end else begin
                i = 9'($urandom_range(0, 347));
            end
            send_beat(CMD_QUERY, 8'($urandom_range(0, 255)), i, 1'b0, RES_NO_RESULT);
        end

        // Leaving the odd frame uncleared lets the next one pile on top of it
        if ($urandom_range(0, 19) != 0) begin
            send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 347)),
                      1'b0, RES_NO_RESULT);
        end
    endtask

    // Checks every result beat against the oldest expectation
    always @(posedge aclk) begin : result_check
        ufr_result_t got;
        ufr_result_t want;

        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_device_id, m_channel_id, m_payload_length, m_payload_byte};
            results_seen++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS) begin
                    $display("Unexpected result beat: status %0d dev %0d chan %0d len %0d byte %0d",
                             got.status, got.dev_id, got.chan_id, got.pay_len, got.pay_byte);
                end
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.dev_id !== want.dev_id ||
                    got.chan_id !== want.chan_id || got.pay_len !== want.pay_len ||
                    got.pay_byte !== want.pay_byte) begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS) begin
                        $display("Result %0d mismatch: expected status %0d dev %0d chan %0d len %0d byte %0d",
                                 results_seen, want.status, want.dev_id, want.chan_id,
                                 want.pay_len, want.pay_byte);
                        $display("    got status %0d dev %0d chan %0d len %0d byte %0d",
                                 got.status, got.dev_id, got.chan_id, got.pay_len, got.pay_byte);
                    end
                end
            end
        end
    end

    // Stimulus sequence
    initial begin : stimulus
        int unsigned phase_start;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < OPENING_ROWS; r++) begin
            send_beat(opening_rows[r].cmd, opening_rows[r].data, opening_rows[r].idx,
                      opening_rows[r].typed, opening_rows[r].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            if (p != 0) begin
                write_limit(CFG_MIN_PAYLOAD, LEN_W'(plan_min[p]));
                write_limit(CFG_MAX_PAYLOAD, LEN_W'(plan_max[p]));
            end
            case (plan_mode[p])
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            phase_start = beats_sent;
            while (beats_sent - phase_start < plan_beats[p]) begin
                send_frame();
                if ($urandom_range(0, 14) == 0) begin
                    wait_for_results();
                end
            end
        end

        wait_for_results();
        sink_stall_pct = 0;
        repeat (8) @(posedge aclk);

        $display("Run covered %0d beats in %0d frame attempts over %0d limit settings,",
                 beats_sent, frames_sent, PHASES);
        $display("with %0d results checked and %0d failures.", results_seen, fail_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
